// File: design/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and codes for the indexed min-heap queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package imhq_pkg;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_UPDATE = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_APPEND,
      S_POP_RD,
      S_POP_SW,
      S_POP_WR,
      S_SW_RD,
      S_SW_KEY,
      S_SW_CMP,
      S_SW_WR,
      S_SK_RD,
      S_SK_KEY,
      S_SK_CMP,
      S_SK_WR,
      S_FR_RD,
      S_FR_KEY,
      S_DONE
   } state_type;

   // one command: the controller names a step, the datapath performs it
   typedef enum logic [3:0] {
      C_NONE,
      C_LATCH,
      C_DECIDE,
      C_APPEND,
      C_POP_RD,
      C_POP_SW,
      C_POP_WR,
      C_SW_RD,
      C_SW_KEY,
      C_SW_WR,
      C_SK_RD,
      C_SK_KEY,
      C_SK_WR,
      C_FR_RD,
      C_FR_KEY,
      C_CLEAR
   } cmd_type;

   typedef struct packed {
      logic clr_last;       // clearing pass at last node
      logic is_ok_present;  // update path on present node
      logic is_append;      // insert of new node
      logic is_pop;         // pop of non-empty heap
      logic sw_go;          // swim step needs swap
      logic sk_more;        // sink has a child
      logic sk_go;          // sink step needs swap
   } status_type;

endpackage
`default_nettype wire

// File: design/imhq_datapath.sv
// ----------------------------------------------------------------------------
// imhq_datapath
// Heap, key, position and membership stores with the compare and swap path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module imhq_datapath #(
   parameter int CAPACITY   = 1024,
   parameter int NODE_COUNT = 4096,
   parameter int KEY_BITS   = 32,
   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
   input  wire                  clock,
   input  wire                  reset,
   input  imhq_pkg::cmd_type    cmd,
   output imhq_pkg::status_type stat,
   input  wire  [1:0]           in_mode,
   input  wire  [11:0]          in_node,
   input  wire  [31:0]          in_key,
   output logic [1:0]           o_status,
   output logic [11:0]          o_pnode,
   output logic [31:0]          o_pkey,
   output logic [11:0]          o_fnode,
   output logic [31:0]          o_fkey,
   output logic [10:0]          o_count
);
   import imhq_pkg::*;

   logic [NW-1:0]       heap_mem    [CAPACITY];
   logic [KEY_BITS-1:0] key_mem     [NODE_COUNT];
   logic [PW-1:0]       pos_mem     [NODE_COUNT];
   logic                present_mem [NODE_COUNT];

   logic [NW-1:0]       clr_ff;
   logic [CW-1:0]       count_ff;
   logic [1:0]          mode_ff;
   logic [11:0]         node_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [1:0]          status_ff;
   logic [NW-1:0]       pnode_ff;
   logic [KEY_BITS-1:0] pkey_ff;
   logic [NW-1:0]       fnode_ff;
   logic [KEY_BITS-1:0] fkey_ff;
   logic                id_ok_ff;
   logic                pres_ff;
   logic [PW-1:0]       pos_ff;    // current position
   logic [PW-1:0]       oth_ff;    // parent
   logic [NW-1:0]       na_ff, nb_ff, nc_ff;  // node at pos, first child (parent in swim), second child
   logic [KEY_BITS-1:0] ka_ff, kb_ff, kc_ff;
   logic                has2_ff;
   logic [NW-1:0]       lastn_ff;

   logic [CW:0]         ch1, ch2;
   logic [NW-1:0]       id_nw;
   logic                b_pick_c;

   assign id_nw = node_ff[NW-1:0];
   assign ch1 = {pos_ff, 1'b1} + (CW+1)'(0);
   assign ch2 = ch1 + (CW+1)'(1);
   assign b_pick_c = has2_ff && (kb_ff > kc_ff);

   always_comb begin
      stat.clr_last = clr_ff == NW'(NODE_COUNT - 1);
      stat.is_ok_present = id_ok_ff && pres_ff && (mode_ff == MODE_INSERT ||
                                                   mode_ff == MODE_UPDATE);
      stat.is_append = id_ok_ff && !pres_ff && mode_ff == MODE_INSERT &&
                       count_ff < CW'(CAPACITY);
      stat.is_pop    = mode_ff == MODE_POP && count_ff != '0;
      stat.sw_go     = pos_ff != '0 && kb_ff > ka_ff;
      stat.sk_more   = (CW+1)'(ch1) < (CW+1)'(count_ff) && ch1 < (CW+1)'(CAPACITY);
      stat.sk_go     = b_pick_c ? (ka_ff > kc_ff) : (ka_ff > kb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         case (cmd)
            C_CLEAR: begin
               present_mem[clr_ff] <= 1'b0;
               clr_ff <= clr_ff + NW'(1);
            end
            C_LATCH: begin
               mode_ff  <= in_mode;
               node_ff  <= in_node;
               key_ff   <= KEY_BITS'(in_key);
               pnode_ff <= '0;
               pkey_ff  <= '0;
               status_ff <= ST_OK;
            end
            C_DECIDE: begin
               id_ok_ff <= 32'(node_ff) < NODE_COUNT;
               pres_ff  <= (32'(node_ff) < NODE_COUNT) ? present_mem[id_nw] : 1'b0;
               pos_ff   <= pos_mem[id_nw];
               lastn_ff <= heap_mem[PW'(count_ff - CW'(1))];
            end
            C_APPEND: begin
               if (mode_ff == MODE_INSERT || mode_ff == MODE_UPDATE) begin
                  if (!id_ok_ff)
                     status_ff <= ST_ABSENT;
                  else if (pres_ff)
                     status_ff <= ST_OK;
                  else if (mode_ff == MODE_UPDATE)
                     status_ff <= ST_ABSENT;
                  else if (count_ff >= CW'(CAPACITY))
                     status_ff <= ST_FULL;
               end else if (mode_ff == MODE_POP && count_ff == '0) begin
                  status_ff <= ST_EMPTY;
               end
               if (stat.is_ok_present) begin
                  key_mem[id_nw] <= key_ff;
               end else if (stat.is_append) begin
                  key_mem[id_nw]  <= key_ff;
                  present_mem[id_nw] <= 1'b1;
                  pos_mem[id_nw]  <= PW'(count_ff);
                  heap_mem[PW'(count_ff)] <= id_nw;
                  pos_ff   <= PW'(count_ff);
                  count_ff <= count_ff + CW'(1);
               end
            end
            C_POP_RD: begin
               pnode_ff <= heap_mem[0];
            end
            C_POP_SW: begin
               heap_mem[0] <= lastn_ff;
               pos_mem[lastn_ff] <= '0;
               present_mem[pnode_ff] <= 1'b0;
               pkey_ff  <= key_mem[pnode_ff];
               count_ff <= count_ff - CW'(1);
               pos_ff   <= '0;
            end
            C_POP_WR: begin
               heap_mem[PW'(count_ff)] <= pnode_ff;
               pos_mem[pnode_ff] <= PW'(count_ff);
               na_ff <= lastn_ff;
               ka_ff <= key_mem[lastn_ff];
            end
            C_SW_RD: begin
               oth_ff <= PW'((pos_ff - PW'(1)) >> 1);
               na_ff  <= heap_mem[pos_ff];
               nb_ff  <= heap_mem[PW'((pos_ff - PW'(1)) >> 1)];
            end
            C_SW_KEY: begin
               ka_ff <= key_mem[na_ff];
               kb_ff <= key_mem[nb_ff];
            end
            C_SW_WR: begin
               heap_mem[oth_ff] <= na_ff;
               heap_mem[pos_ff] <= nb_ff;
               pos_mem[na_ff]   <= oth_ff;
               pos_mem[nb_ff]   <= pos_ff;
               pos_ff <= oth_ff;
            end
            C_SK_RD: begin
               has2_ff <= ch2 < (CW+1)'(count_ff);
               nb_ff <= heap_mem[PW'(ch1)];
               nc_ff <= heap_mem[PW'(ch2)];
            end
            C_SK_KEY: begin
               kb_ff <= key_mem[nb_ff];
               kc_ff <= key_mem[nc_ff];
            end
            C_SK_WR: begin
               if (b_pick_c) begin
                  if (stat.sk_go) begin
                     heap_mem[PW'(ch2)] <= na_ff;
                     heap_mem[pos_ff]   <= nc_ff;
                     pos_mem[nc_ff]     <= pos_ff;
                     pos_mem[na_ff]     <= PW'(ch2);
                  end else begin
                     na_ff <= nc_ff;
                     ka_ff <= kc_ff;
                  end
                  pos_ff <= PW'(ch2);
               end else begin
                  if (stat.sk_go) begin
                     heap_mem[PW'(ch1)] <= na_ff;
                     heap_mem[pos_ff]   <= nb_ff;
                     pos_mem[nb_ff]     <= pos_ff;
                     pos_mem[na_ff]     <= PW'(ch1);
                  end else begin
                     na_ff <= nb_ff;
                     ka_ff <= kb_ff;
                  end
                  pos_ff <= PW'(ch1);
               end
            end
            C_FR_RD: begin
               fnode_ff <= heap_mem[0];
            end
            C_FR_KEY: begin
               fkey_ff <= key_mem[fnode_ff];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      o_status = status_ff;
      o_pnode  = 12'(pnode_ff);
      o_pkey   = 32'(pkey_ff);
      o_fnode  = (count_ff != '0) ? 12'(fnode_ff) : 12'd0;
      o_fkey   = (count_ff != '0) ? 32'(fkey_ff) : 32'd0;
      o_count  = 11'(count_ff);
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count over capacity");
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      cmd == C_APPEND && stat.is_append |=> count_ff == $past(count_ff) + CW'(1))
      else $error("append did not grow");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd == C_POP_SW |=> count_ff == $past(count_ff) - CW'(1))
      else $error("pop did not shrink");
`endif
endmodule
`default_nettype wire

// File: design/imhq_ctrl.sv
// ----------------------------------------------------------------------------
// imhq_ctrl
// Sequencer for insert, pop and update walks over the heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module imhq_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_fire,
   input  wire                  rsp_fire,
   input  imhq_pkg::status_type stat,
   output imhq_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 done
);
   import imhq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (stat.clr_last) state_in = S_IDLE;
         S_IDLE:   if (req_fire) state_in = S_DECIDE;
         S_DECIDE: state_in = S_APPEND;
         S_APPEND: begin
            if (stat.is_append || stat.is_ok_present) state_in = S_SW_RD;
            else if (stat.is_pop) state_in = S_POP_RD;
            else state_in = S_FR_RD;
         end
         S_POP_RD: state_in = S_POP_SW;
         S_POP_SW: state_in = S_POP_WR;
         S_POP_WR: state_in = S_SK_CMP;
         S_SW_RD:  state_in = S_SW_KEY;
         S_SW_KEY: state_in = S_SW_CMP;
         S_SW_CMP: state_in = stat.sw_go ? S_SW_WR : S_FR_RD;
         S_SW_WR:  state_in = S_SW_RD;
         S_SK_CMP: state_in = stat.sk_more ? S_SK_RD : S_FR_RD;
         S_SK_RD:  state_in = S_SK_KEY;
         S_SK_KEY: state_in = S_SK_WR;
         S_SK_WR:  state_in = S_SK_CMP;
         S_FR_RD:  state_in = S_FR_KEY;
         S_FR_KEY: state_in = S_DONE;
         S_DONE:   if (rsp_fire) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = C_NONE;
      busy = 1'b1;
      done = 1'b0;
      unique case (state_ff)
         S_CLEAR:  cmd = C_CLEAR;
         S_IDLE:   begin busy = 1'b0; if (req_fire) cmd = C_LATCH; end
         S_DECIDE: cmd = C_DECIDE;
         S_APPEND: cmd = C_APPEND;
         S_POP_RD: cmd = C_POP_RD;
         S_POP_SW: cmd = C_POP_SW;
         S_POP_WR: cmd = C_POP_WR;
         S_SW_RD:  cmd = C_SW_RD;
         S_SW_KEY: cmd = C_SW_KEY;
         S_SW_CMP: cmd = C_NONE;
         S_SW_WR:  cmd = C_SW_WR;
         S_SK_CMP: cmd = C_NONE;
         S_SK_RD:  cmd = C_SK_RD;
         S_SK_KEY: cmd = C_SK_KEY;
         S_SK_WR:  cmd = C_SK_WR;
         S_FR_RD:  cmd = C_FR_RD;
         S_FR_KEY: cmd = C_FR_KEY;
         S_DONE:   done = 1'b1;
         default:  cmd = C_NONE;
      endcase
   end

`ifndef ASSERT_OFF
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !done) else $error("result while idle");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done && !rsp_fire |=> done) else $error("result dropped");
   a_latch_idle: assert property (@(posedge clock) disable iff (reset)
      cmd == C_LATCH |-> !busy) else $error("latch while busy");
`endif
endmodule
`default_nettype wire

// File: design/indexed_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top
// Indexed binary min-heap queue: insert, pop front, decrease key.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low first)
// req     | in  | mode[1:0], node_id[13:2], key[45:14]
// rsp     | out | status, popped_node, popped_key, front_node, front_key, count,
//         |     | is_empty
// One transaction at a time. An insert or update swims its node up one heap
// level per swap; a pop moves the last node to the root and sinks it level by
// level; a rejected or unused request skips the walk. Each then reads the
// front node and key for the result. After reset a clearing pass zeroes the
// membership bit of every node, one node at a time, with req_tready low.
// A stalled result holds the block until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue_top #(
   parameter int CAPACITY   = 1024,
   parameter int NODE_COUNT = 4096,
   parameter int KEY_BITS   = 32
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [47:0]  req_tdata,   // mode, node_id, key
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [103:0] rsp_tdata    // status, popped_node, popped_key,
                                     // front_node, front_key, count, is_empty
);
   import imhq_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic busy, done;
   logic [1:0]  o_status;
   logic [11:0] o_pnode, o_fnode;
   logic [31:0] o_pkey, o_fkey;
   logic [10:0] o_count;

   assign req_tready = !busy;
   assign rsp_tvalid = done;
   assign rsp_tdata = {2'b00, (o_count == 11'd0), o_count, o_fkey, o_fnode,
                       o_pkey, o_pnode, o_status};

   imhq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready),
      .rsp_fire(rsp_tvalid && rsp_tready),
      .stat(stat), .cmd(cmd), .busy(busy), .done(done)
   );

   imhq_datapath #(.CAPACITY(CAPACITY), .NODE_COUNT(NODE_COUNT),
                   .KEY_BITS(KEY_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_mode(req_tdata[1:0]), .in_node(req_tdata[13:2]),
      .in_key(req_tdata[45:14]),
      .o_status(o_status), .o_pnode(o_pnode), .o_pkey(o_pkey),
      .o_fnode(o_fnode), .o_fkey(o_fkey), .o_count(o_count)
   );
endmodule
`default_nettype wire

// File: verif/indexed_min_heap_queue_checker.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_checker
// Watches both channels of the heap queue and keeps its own indexed min-heap.
// Each accepted request transaction is predicted, and each result transaction
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue_checker (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [47:0]  req_tdata,   // mode, node_id, key
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [103:0] rsp_tdata,   // status, popped_node, popped_key,
                                     // front_node, front_key, count, is_empty
   output int           pending,
   output int           failures
);
   import imhq_pkg::*;

   // highest field first, so status lands in the lowest bits
   typedef struct packed {
      logic        is_empty;
      logic [10:0] count;
      logic [31:0] front_key;
      logic [11:0] front_node;
      logic [31:0] popped_key;
      logic [11:0] popped_node;
      logic [1:0]  status;
   } heap_result_type;

   localparam int SLOTS = 1024;
   localparam int NODES = 4096;

   logic [11:0] slot_node [SLOTS];
   logic [31:0] node_key  [NODES];
   logic [9:0]  node_pos  [NODES];
   bit          in_heap   [NODES];
   int          heap_size;
   heap_result_type result_q [$];

   function automatic logic [31:0] key_of(int p);
      return node_key[slot_node[p]];
   endfunction

   task automatic swap_slots(int a, int b);
      logic [11:0] t;
      t = slot_node[a];
      slot_node[a] = slot_node[b];
      slot_node[b] = t;
      node_pos[slot_node[a]] = a[9:0];
      node_pos[slot_node[b]] = b[9:0];
   endtask

   task automatic swim(int p);
      int up;
      while (p > 0) begin
         up = (p - 1) / 2;
         if (!(key_of(up) > key_of(p))) break;
         swap_slots(up, p);
         p = up;
      end
   endtask

   task automatic sink(int p);
      int ch;
      ch = 2 * p + 1;
      while (ch < heap_size) begin
         if (ch + 1 < heap_size && key_of(ch) > key_of(ch + 1)) ch++;
         if (key_of(p) > key_of(ch)) swap_slots(p, ch);
         p = ch;
         ch = 2 * p + 1;
      end
   endtask

   task automatic apply_request(logic [1:0] mode, logic [11:0] id, logic [31:0] key);
      heap_result_type r;
      logic [11:0] gone;
      r = '0;
      r.status = ST_OK;
      if (mode == MODE_INSERT || mode == MODE_UPDATE) begin
         if (in_heap[id]) begin
            node_key[id] = key;
            swim(int'(node_pos[id]));
         end else if (mode == MODE_UPDATE) begin
            r.status = ST_ABSENT;
         end else if (heap_size >= SLOTS) begin
            r.status = ST_FULL;
         end else begin
            node_key[id] = key;
            in_heap[id] = 1'b1;
            node_pos[id] = heap_size[9:0];
            slot_node[heap_size] = id;
            heap_size++;
            swim(heap_size - 1);
         end
      end else if (mode == MODE_POP) begin
         if (heap_size == 0) begin
            r.status = ST_EMPTY;
         end else begin
            swap_slots(0, heap_size - 1);
            gone = slot_node[heap_size - 1];
            heap_size--;
            in_heap[gone] = 1'b0;
            r.popped_node = gone;
            r.popped_key = node_key[gone];
            sink(0);
         end
      end
      if (heap_size > 0) begin
         r.front_node = slot_node[0];
         r.front_key = key_of(0);
      end
      r.count = heap_size[10:0];
      r.is_empty = (heap_size == 0);
      result_q.push_back(r);
   endtask

   always @(posedge clock) begin
      heap_result_type got, want;
      if (reset) begin
         heap_size = 0;
         foreach (in_heap[i]) in_heap[i] = 1'b0;
         result_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            apply_request(req_tdata[1:0], req_tdata[13:2], req_tdata[45:14]);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[101:0];
            if (result_q.size() == 0) begin
               $error("unexpected result transaction %h", rsp_tdata);
               failures++;
            end else begin
               want = result_q[0];
               result_q.delete(0);
               if (got.status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  failures++;
               end
               if (got.popped_node != want.popped_node) begin
                  $error("popped_node: expected %0d, got %0d",
                         want.popped_node, got.popped_node);
                  failures++;
               end
               if (got.popped_key != want.popped_key) begin
                  $error("popped_key: expected %h, got %h", want.popped_key, got.popped_key);
                  failures++;
               end
               if (got.front_node != want.front_node) begin
                  $error("front_node: expected %0d, got %0d",
                         want.front_node, got.front_node);
                  failures++;
               end
               if (got.front_key != want.front_key) begin
                  $error("front_key: expected %h, got %h", want.front_key, got.front_key);
                  failures++;
               end
               if (got.count != want.count) begin
                  $error("count: expected %0d, got %0d", want.count, got.count);
                  failures++;
               end
               if (got.is_empty != want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                  failures++;
               end
            end
         end
      end
      pending = result_q.size();
   end

endmodule
`default_nettype wire

// File: verif/indexed_min_heap_queue_top_test.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top_test
// Drives insert, pop and update transactions into the heap queue: a directed
// opening, a bulk fill, then a random mix under random back-pressure.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue_top_test;
   import imhq_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic [47:0]   req_tdata = '0;
   logic          rsp_tready = 1'b0;
   wire           req_tready;
   wire           rsp_tvalid;
   wire  [103:0]  rsp_tdata;
   int            pending;
   int            failures;
   bit            hold_rsp = 1'b0;
   bit            hold_done = 1'b0;

   indexed_min_heap_queue_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   indexed_min_heap_queue_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .pending(pending), .failures(failures)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(1, 3);
   endfunction

   task automatic send(logic [1:0] mode, logic [11:0] id, logic [31:0] key);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, key, id, mode};
      do @(posedge clock); while (!req_tready);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 9) < 7) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 19) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [1:0]  m;
      logic [11:0] id;
      logic [31:0] k;
      int sel;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening
      send(MODE_POP, 12'd0, 32'd0);
      send(MODE_UPDATE, 12'd5, 32'd1);
      send(MODE_UNUSED, 12'hFFF, 32'hFFFF_FFFF);
      send(MODE_INSERT, 12'hFFF, 32'hFFFF_FFFF);
      send(MODE_INSERT, 12'd0, 32'd0);
      send(MODE_INSERT, 12'h800, 32'h8000_0000);
      send(MODE_INSERT, 12'h555, 32'h0001_0000);
      send(MODE_INSERT, 12'hFFF, 32'd1);
      send(MODE_UPDATE, 12'h800, 32'd0);
      send(MODE_UPDATE, 12'd0, 32'hFFFF_FFFF);
      send(MODE_UPDATE, 12'h123, 32'd7);
      send(MODE_UNUSED, 12'h0AA, 32'h5555_5555);
      repeat (5) send(MODE_POP, 12'd0, 32'd0);
      send(MODE_POP, 12'd0, 32'd0);

      // bulk fill with distinct ids, then a few inserts and an update
      for (int i = 0; i < 600; i++) begin
         id = 12'((i * 7 + 3) % 4096);
         send(MODE_INSERT, id, $urandom);
      end
      drain_wait();
      send(MODE_INSERT, 12'd1, $urandom);
      send(MODE_INSERT, 12'd2, 32'd0);
      send(MODE_INSERT, 12'd3, 32'd0);
      send(MODE_UPDATE, 12'd10, 32'd0);

      // long receiver hold-off while requests keep coming
      hold_rsp = 1'b1;
      for (int i = 0; i < 12; i++) send(MODE_POP, 12'd0, 32'd0);

      // random mix, pop-leaning so the heap shrinks through many sizes
      for (int i = 0; i < 316; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 30) m = MODE_INSERT;
         else if (sel < 70) m = MODE_POP;
         else if (sel < 96) m = MODE_UPDATE;
         else m = MODE_UNUSED;
         if ($urandom_range(0, 3) == 0) id = 12'($urandom);
         else id = 12'(($urandom_range(0, 200) * 7 + 3) % 4096);
         if (m == MODE_UPDATE && $urandom_range(0, 9) < 8)
            k = $urandom >> $urandom_range(4, 31);
         else
            k = $urandom;
         send(m, id, k);
      end

      drain_wait();
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
